FILE: rtl/slpg_pkg.sv
// shared constants, codes and control structs of the sobol leapfrog point generator
package slpg_pkg;

  // default configuration of the generator
  localparam int DIMENSIONS_DEF = 32;
  localparam int WORD_BITS_DEF  = 32;
  localparam int MAX_OUT        = 32;

  // port field widths
  localparam int OP_W       = 2;
  localparam int DIM_W      = 5;
  localparam int LVL_W      = 5;
  localparam int IN_WORD_W  = 32;
  localparam int COORD_W    = 32;
  localparam int LS_W       = 4;
  localparam int OFS_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_PREPARE = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEAP_SHIFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 2'd1;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic clr;          // clear point and common word
    logic acc_xor;      // fold direction word into the point
    logic take_common;  // capture direction word as the common leap term
    logic leap_wr;      // write one leap word
    logic shift;        // rotate points one cell toward cell 0
    logic upd;          // xor the fetched leap word into the point
  } cell_ctl_t;

  // result request from the sequencer to the output register
  typedef struct packed {
    logic             emit;
    logic [DIM_W-1:0] dim_index;
    logic             last;
    logic             exhausted;
  } out_req_t;

endpackage

FILE: rtl/slpg_cell.sv
// one dimension of the generator: direction and leap words plus the point word
module slpg_cell #(
  parameter int WORD_BITS = slpg_pkg::WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  slpg_pkg::cell_ctl_t          ctl,
  input  logic [$clog2(WORD_BITS)-1:0] rd_addr,
  input  logic [$clog2(WORD_BITS)-1:0] wr_addr,
  input  logic                         dir_we,
  input  logic [$clog2(WORD_BITS)-1:0] dir_wa,
  input  logic [WORD_BITS-1:0]         dir_wd,
  input  logic [WORD_BITS-1:0]         point_in,
  output logic [WORD_BITS-1:0]         point_out
);
  import slpg_pkg::*;

  logic [WORD_BITS-1:0] dir_mem [WORD_BITS];
  logic [WORD_BITS-1:0] leap_mem [WORD_BITS];
  logic [WORD_BITS-1:0] dir_q_r;
  logic [WORD_BITS-1:0] leap_q_r;
  logic [WORD_BITS-1:0] common_r;
  logic [WORD_BITS-1:0] point_r;

  assign point_out = point_r;

  // direction words, written by load requests
  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_wa] <= dir_wd;
    end
    dir_q_r <= dir_mem[rd_addr];
  end

  // leap words, written during the second prepare sweep
  always_ff @(posedge clk) begin
    if (ctl.leap_wr) begin
      leap_mem[wr_addr] <= dir_q_r ^ common_r;
    end
    leap_q_r <= leap_mem[rd_addr];
  end

  // common leap term: direction word at level leap_shift - 1
  always_ff @(posedge clk) begin
    priority if (ctl.clr) begin
      common_r <= '0;
    end else if (ctl.take_common) begin
      common_r <= dir_q_r;
    end else begin
      common_r <= common_r;
    end
  end

  // point word: start point build, ring rotation, leap update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_r <= '0;
    end else begin
      priority if (ctl.clr) begin
        point_r <= '0;
      end else if (ctl.acc_xor) begin
        point_r <= point_r ^ dir_q_r;
      end else if (ctl.shift) begin
        point_r <= point_in;
      end else if (ctl.upd) begin
        point_r <= point_r ^ leap_q_r;
      end else begin
        point_r <= point_r;
      end
    end
  end

endmodule

FILE: rtl/slpg_ctrl.sv
// sequencer: registers, step count, trailing-zero scan and per-request phases
module slpg_ctrl #(
  parameter int DIMENSIONS = slpg_pkg::DIMENSIONS_DEF,
  parameter int WORD_BITS  = slpg_pkg::WORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [slpg_pkg::OP_W-1:0]         in_operation,
  input  logic                              cfg_valid,
  input  logic [slpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slpg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              out_ready,
  output slpg_pkg::cell_ctl_t               ctl,
  output logic [$clog2(WORD_BITS)-1:0]      rd_addr,
  output logic [$clog2(WORD_BITS)-1:0]      wr_addr,
  output slpg_pkg::out_req_t                req
);
  import slpg_pkg::*;

  localparam int LW   = $clog2(WORD_BITS);
  localparam int CW   = $clog2(WORD_BITS + 1);
  localparam int SW   = $clog2(DIMENSIONS + 1);
  localparam int NOUT = (DIMENSIONS < MAX_OUT) ? DIMENSIONS : MAX_OUT;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_PREP_A   = 3'd1;
  localparam logic [2:0] ST_PREP_B   = 3'd2;
  localparam logic [2:0] ST_EMIT     = 3'd3;
  localparam logic [2:0] ST_UPD_WAIT = 3'd4;
  localparam logic [2:0] ST_UPD_XOR  = 3'd5;

  logic [2:0]           state_r;
  logic [CW-1:0]        c_r;
  logic [SW-1:0]        sh_r;
  logic [WORD_BITS-1:0] count_r;
  logic [WORD_BITS-1:0] scan_r;
  logic [CW-1:0]        tz_r;
  logic                 scan_busy_r;
  logic                 exh_r;
  logic [LS_W-1:0]      leap_shift_r;
  logic [OFS_W-1:0]     start_offset_r;

  logic                 accept;
  logic                 s_big;
  logic [WORD_BITS-1:0] stride;
  logic [WORD_BITS:0]   sum;
  logic                 exh_now;
  logic                 scan_start;
  logic [CW-1:0]        idx_w;
  logic [LW-1:0]        idx;
  logic                 data_ph;
  logic [OFS_W-1:0]     gray;
  logic [OFS_W-1:0]     gray_sh;
  logic                 can_shift;
  logic                 c_done;
  logic                 sh_last;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // stride and wrap check of the step count
  assign s_big   = (32'(leap_shift_r) >= WORD_BITS);
  assign stride  = s_big ? '0 : (WORD_BITS'(1) << leap_shift_r);
  assign sum     = {1'b0, count_r} + {1'b0, stride};
  assign exh_now = s_big || sum[WORD_BITS];
  assign scan_start = accept && (in_operation == OP_NEXT) && !exh_now;

  // sweep index c_r - 1; the registered read data belongs to that level
  assign idx_w   = c_r - CW'(1);
  assign idx     = idx_w[LW-1:0];
  assign data_ph = (c_r != '0);
  assign c_done  = (c_r == CW'(WORD_BITS));

  // gray code of the start offset selects the levels of the start point
  assign gray    = start_offset_r ^ (start_offset_r >> 1);
  assign gray_sh = gray >> idx;

  assign can_shift = (32'(sh_r) >= NOUT) || out_ready;
  assign sh_last   = (sh_r == SW'(DIMENSIONS - 1));

  // cell control
  always_comb begin
    ctl.clr         = (state_r == ST_PREP_A) && !data_ph;
    ctl.acc_xor     = (state_r == ST_PREP_A) && data_ph && gray_sh[0];
    ctl.take_common = (state_r == ST_PREP_A) && data_ph && (leap_shift_r != '0) &&
                      (32'(idx) + 32'd1 == 32'(leap_shift_r));
    ctl.leap_wr     = (state_r == ST_PREP_B) && data_ph;
    ctl.shift       = (state_r == ST_EMIT) && can_shift;
    ctl.upd         = (state_r == ST_UPD_XOR);
  end

  assign rd_addr = (state_r == ST_UPD_WAIT) ? tz_r[LW-1:0] : c_r[LW-1:0];
  assign wr_addr = idx;

  // result request to the output register
  always_comb begin
    req.emit      = ctl.shift && (32'(sh_r) < NOUT);
    req.dim_index = DIM_W'(sh_r);
    req.last      = (32'(sh_r) == NOUT - 1);
    req.exhausted = exh_r;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leap_shift_r   <= '0;
      start_offset_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LEAP_SHIFT:   leap_shift_r   <= cfg_data[LS_W-1:0];
        CFG_START_OFFSET: start_offset_r <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // phase sequencer and step count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      c_r     <= '0;
      sh_r    <= '0;
      count_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_operation)
              OP_PREPARE: begin
                state_r <= ST_PREP_A;
                c_r     <= '0;
                count_r <= '0;
              end
              OP_NEXT: begin
                state_r <= ST_EMIT;
                sh_r    <= '0;
                if (!exh_now) begin
                  count_r <= sum[WORD_BITS-1:0];
                end
              end
              default: ;
            endcase
          end
        end
        ST_PREP_A: begin
          if (c_done) begin
            state_r <= ST_PREP_B;
            c_r     <= '0;
          end else begin
            c_r <= c_r + CW'(1);
          end
        end
        ST_PREP_B: begin
          if (c_done) begin
            state_r <= ST_IDLE;
            c_r     <= '0;
          end else begin
            c_r <= c_r + CW'(1);
          end
        end
        ST_EMIT: begin
          if (can_shift) begin
            sh_r <= sh_r + SW'(1);
            if (sh_last) begin
              state_r <= exh_r ? ST_IDLE : ST_UPD_WAIT;
            end
          end
        end
        ST_UPD_WAIT: begin
          if (!scan_busy_r) begin
            state_r <= ST_UPD_XOR;
          end
        end
        ST_UPD_XOR: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // trailing-zero scan of the new count, one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_busy_r <= 1'b0;
    end else if (scan_start) begin
      scan_busy_r <= 1'b1;
    end else if (scan_busy_r && scan_r[0]) begin
      scan_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      scan_r <= sum[WORD_BITS-1:0];
      tz_r   <= '0;
    end else if (scan_busy_r && !scan_r[0]) begin
      scan_r <= scan_r >> 1;
      tz_r   <= tz_r + CW'(1);
    end
    if (accept && (in_operation == OP_NEXT)) begin
      exh_r <= exh_now;
    end
  end

endmodule

FILE: rtl/sobol_leapfrog_point_generator.sv
// top level of the sobol leapfrog point generator: cell ring, sequencer, output register
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | operation, dimension, level, word
//   out_    | output    | out_valid/out_stall | dim_index, coordinate, last, exhausted
//   cfg_    | input     | cfg_valid/cfg_ready | index, data (always ready)
//
// a load request writes one direction word and keeps the block idle; a prepare request
// runs two sweeps over the per-cell direction memories (read port bound)
// a next request rotates the point ring once, one shift per dimension, held while the
// output stalls, then waits for the trailing-zero scan of the count (overlapped with the
// rotation) and, unless exhausted, does the leap update
// reset clears points, count and registers; the direction and leap memories hold
// garbage until loaded and prepared; no clearing pass
// the output register keeps the last coordinate while the next request is taken
module sobol_leapfrog_point_generator #(
  parameter int DIMENSIONS = slpg_pkg::DIMENSIONS_DEF,
  parameter int WORD_BITS  = slpg_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [slpg_pkg::OP_W-1:0]       in_operation,
  input  logic [slpg_pkg::DIM_W-1:0]      in_dimension,
  input  logic [slpg_pkg::LVL_W-1:0]      in_level,
  input  logic [slpg_pkg::IN_WORD_W-1:0]  in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [slpg_pkg::DIM_W-1:0]      out_dim_index,
  output logic [slpg_pkg::COORD_W-1:0]    out_coordinate,
  output logic                            out_last,
  output logic                            out_exhausted,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slpg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import slpg_pkg::*;

  localparam int LW = $clog2(WORD_BITS);

  cell_ctl_t            ctl;
  out_req_t             req;
  logic [LW-1:0]        rd_addr;
  logic [LW-1:0]        wr_addr;
  logic                 out_ready;
  logic                 load_go;
  logic [LW-1:0]        dir_wa;
  logic [WORD_BITS-1:0] dir_wd;
  logic [WORD_BITS-1:0] ring_w [DIMENSIONS];
  logic [COORD_W-1:0]   frac;

  logic                 out_valid_r;
  logic [DIM_W-1:0]     dim_index_r;
  logic [COORD_W-1:0]   coordinate_r;
  logic                 last_r;
  logic                 exhausted_r;

  assign cfg_ready = 1'b1;
  assign out_ready = !out_valid_r || !out_stall;

  // load request decode
  assign load_go = in_valid && !in_stall && (in_operation == OP_LOAD) &&
                   (32'(in_level) < WORD_BITS) && (32'(in_dimension) < DIMENSIONS);
  assign dir_wa  = LW'(in_level);
  assign dir_wd  = WORD_BITS'(in_word);

  slpg_ctrl #(
    .DIMENSIONS (DIMENSIONS),
    .WORD_BITS  (WORD_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_ready    (out_ready),
    .ctl          (ctl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .req          (req)
  );

  // ring of cells, each passing its point toward cell 0
  for (genvar k = 0; k < DIMENSIONS; k++) begin : g_cell
    slpg_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .dir_we    (load_go && (32'(in_dimension) == k)),
      .dir_wa    (dir_wa),
      .dir_wd    (dir_wd),
      .point_in  (ring_w[(k + 1) % DIMENSIONS]),
      .point_out (ring_w[k])
    );
  end

  // scale the point word to a 0.32 fraction
  if (WORD_BITS >= COORD_W) begin : g_frac_trunc
    assign frac = ring_w[0][WORD_BITS-1 -: COORD_W];
  end else begin : g_frac_shift
    assign frac = COORD_W'(ring_w[0]) << (COORD_W - WORD_BITS);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.emit) begin
      dim_index_r  <= req.dim_index;
      coordinate_r <= frac;
      last_r       <= req.last;
      exhausted_r  <= req.exhausted;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dim_index  = dim_index_r;
  assign out_coordinate = coordinate_r;
  assign out_last       = last_r;
  assign out_exhausted  = exhausted_r;

endmodule

FILE: tb/sobol_leapfrog_point_generator_tb.sv
// self-checking testbench of the sobol leapfrog point generator with a built-in point predictor
`timescale 1ns / 1ps

module sobol_leapfrog_point_generator_tb;
  import slpg_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 100;
  localparam int FILL_LEVELS   = 8;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [DIM_W-1:0]     dim;
    logic [LVL_W-1:0]     lvl;
    logic [IN_WORD_W-1:0] word;
  } request_t;

  typedef struct packed {
    logic [DIM_W-1:0]   dim_index;
    logic [COORD_W-1:0] coordinate;
    logic               last;
    logic               exhausted;
  } coord_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_operation = '0;
  logic [DIM_W-1:0]      in_dimension = '0;
  logic [LVL_W-1:0]      in_level = '0;
  logic [IN_WORD_W-1:0]  in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DIM_W-1:0]      out_dim_index;
  logic [COORD_W-1:0]    out_coordinate;
  logic                  out_last;
  logic                  out_exhausted;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [WORD_BITS_DEF-1:0] dir_tab [DIMENSIONS_DEF][WORD_BITS_DEF];
  logic [WORD_BITS_DEF-1:0] leap_tab [DIMENSIONS_DEF][WORD_BITS_DEF];
  logic [WORD_BITS_DEF-1:0] pt [DIMENSIONS_DEF];
  logic [WORD_BITS_DEF-1:0] step_cnt = '0;
  logic [LS_W-1:0]          shift_r = '0;
  logic [OFS_W-1:0]         ofs_r = '0;

  request_t req_q [$];
  coord_t   coord_want [$];
  request_t held;
  coord_t   want;
  int       pending = 0;
  int       mismatches = 0;
  bit       calm = 1'b0;

  sobol_leapfrog_point_generator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_dimension   (in_dimension),
    .in_level       (in_level),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dim_index  (out_dim_index),
    .out_coordinate (out_coordinate),
    .out_last       (out_last),
    .out_exhausted  (out_exhausted),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // trailing zeros, 64 for a zero word
  function automatic int trailing_zeros(input logic [WORD_BITS_DEF-1:0] v);
    int n;
    if (v == '0) return 64;
    n = 0;
    while (!v[n]) n++;
    return n;
  endfunction

  // apply one accepted request to the predicted generator state
  task automatic advance_sobol(input request_t r);
    logic [WORD_BITS_DEF:0]   stride;
    logic [WORD_BITS_DEF-1:0] common;
    int                       t;
    bit                       exh;
    coord_t                   c;
    case (r.op)
      OP_LOAD: begin
        dir_tab[r.dim][r.lvl] = r.word;
      end
      OP_PREPARE: begin
        // xor over one stride folds down to the word at level shift-1
        for (int k = 0; k < DIMENSIONS_DEF; k++) begin
          common = (shift_r != '0) ? dir_tab[k][shift_r - 4'd1] : '0;
          for (int j = 0; j < WORD_BITS_DEF; j++)
            leap_tab[k][j] = dir_tab[k][j] ^ common;
          pt[k] = '0;
        end
        step_cnt = '0;
        // single gray-code steps up to the stream index
        for (int n = 1; n <= int'(ofs_r); n++) begin
          t = trailing_zeros(n);
          for (int k = 0; k < DIMENSIONS_DEF; k++)
            pt[k] ^= dir_tab[k][t];
        end
      end
      OP_NEXT: begin
        stride = (WORD_BITS_DEF + 1)'(1) << shift_r;
        exh = ({1'b0, step_cnt} + stride) > {1'b0, {WORD_BITS_DEF{1'b1}}};
        for (int k = 0; k < DIMENSIONS_DEF; k++) begin
          c.dim_index  = DIM_W'(k);
          c.coordinate = pt[k];
          c.last       = (k == DIMENSIONS_DEF - 1);
          c.exhausted  = exh;
          coord_want.push_back(c);
        end
        // leap to the next point of this stream
        if (!exh) begin
          step_cnt = step_cnt + stride[WORD_BITS_DEF-1:0];
          t = trailing_zeros(step_cnt);
          if (t < WORD_BITS_DEF)
            for (int d = 0; d < DIMENSIONS_DEF; d++)
              pt[d] ^= leap_tab[d][t];
        end
      end
      default: ;
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        advance_sobol(held);
        pending--;
      end
      if (req_q.size() != 0 && !(!calm && $urandom_range(0, 99) < 7)) begin
        held = req_q.pop_front();
        in_valid     <= 1'b1;
        in_operation <= held.op;
        in_dimension <= held.dim;
        in_level     <= held.lvl;
        in_word      <= held.word;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // coordinate monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (coord_want.size() == 0) begin
          $error("coordinate with no request pending: dim_index %0d coordinate %h",
                 out_dim_index, out_coordinate);
          mismatches++;
        end else begin
          want = coord_want.pop_front();
          if (out_dim_index !== want.dim_index) begin
            $error("dim_index: expected %0d, got %0d", want.dim_index, out_dim_index);
            mismatches++;
          end
          if (out_coordinate !== want.coordinate) begin
            $error("coordinate: expected %h, got %h", want.coordinate, out_coordinate);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_last);
            mismatches++;
          end
          if (out_exhausted !== want.exhausted) begin
            $error("exhausted: expected %b, got %b", want.exhausted, out_exhausted);
            mismatches++;
          end
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end
  end

  task automatic queue_req(input logic [OP_W-1:0] op, input logic [DIM_W-1:0] dim,
                           input logic [LVL_W-1:0] lvl, input logic [IN_WORD_W-1:0] word);
    request_t r;
    r.op   = op;
    r.dim  = dim;
    r.lvl  = lvl;
    r.word = word;
    pending++;
    req_q.push_back(r);
  endtask

  // wait until every request is taken and every coordinate has come, then let the block settle
  task automatic wait_idle();
    do @(posedge clk); while (pending != 0 || coord_want.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LEAP_SHIFT:   shift_r = val[LS_W-1:0];
      CFG_START_OFFSET: ofs_r = val[OFS_W-1:0];
      default: ;
    endcase
  endtask

  // one register setting followed by a random request mix
  task automatic run_phase(input int ls, input int ofs, input bit prep_first, input bit quiet,
                           input int count);
    int              n;
    int              r;
    logic [OP_W-1:0] op;
    wait_idle();
    calm = quiet;
    write_reg(CFG_LEAP_SHIFT, CFG_DATA_W'(ls));
    if (ofs >= 0) write_reg(CFG_START_OFFSET, CFG_DATA_W'(ofs));
    if (prep_first)
      queue_req(OP_PREPARE, DIM_W'($urandom_range(0, 31)), LVL_W'($urandom_range(0, 31)),
                $urandom());
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 99);
      if (r < 68)
        op = OP_NEXT;
      else if (r < 80)
        op = OP_LOAD;
      else if (r < 88)
        op = OP_PREPARE;
      else
        op = OP_UNUSED;
      queue_req(op, DIM_W'($urandom_range(0, 31)), LVL_W'($urandom_range(0, 31)), $urandom());
      if (r < 88) n++;
    end
  endtask

  // stimulus
  initial begin
    logic [IN_WORD_W-1:0] w;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the low levels of every dimension; phases keep every level read below them
    for (int d = 0; d < DIMENSIONS_DEF; d++)
      for (int l = 0; l < FILL_LEVELS; l++) begin
        w = $urandom();
        if (d == 0 && l == 0) w = '0;
        if (d == DIMENSIONS_DEF - 1 && l == FILL_LEVELS - 1) w = '1;
        queue_req(OP_LOAD, DIM_W'(d), LVL_W'(l), w);
      end

    // directed: stride one from reset, field extremes, unused code
    queue_req(OP_PREPARE, 5'd0, 5'd0, 32'h0);
    queue_req(OP_NEXT, 5'd0, 5'd0, 32'h0);
    queue_req(OP_NEXT, 5'd31, 5'd31, 32'hFFFF_FFFF);
    queue_req(OP_NEXT, 5'd10, 5'd21, 32'h5A5A_A5A5);
    queue_req(OP_LOAD, 5'd31, 5'd31, 32'hFFFF_FFFF);
    queue_req(OP_LOAD, 5'd0, 5'd0, 32'h0000_0000);
    queue_req(OP_LOAD, 5'd21, 5'd10, 32'hA5A5_5A5A);
    queue_req(OP_LOAD, 5'd0, 5'd1, 32'h8000_0001);
    queue_req(OP_UNUSED, 5'd31, 5'd31, 32'hFFFF_FFFF);
    queue_req(OP_UNUSED, 5'd0, 5'd0, 32'h0);
    // loads do not reach the leap table until the next prepare
    queue_req(OP_NEXT, 5'd0, 5'd0, 32'h0);
    queue_req(OP_PREPARE, 5'd31, 5'd31, 32'hFFFF_FFFF);
    queue_req(OP_NEXT, 5'd0, 5'd0, 32'h0);
    queue_req(OP_NEXT, 5'd0, 5'd0, 32'h0);
    queue_req(OP_NEXT, 5'd0, 5'd0, 32'h0);

    // random phases; shift plus count growth stays inside the filled levels
    run_phase(4, 255, 1'b1, 1'b0, 8);
    run_phase(0, 1, 1'b1, 1'b0, 8);
    run_phase(1, 0, 1'b1, 1'b0, 8);
    // widest shift the fill allows, a single step at most
    run_phase(7, 128, 1'b1, 1'b0, 1);
    // leap shift changed with no prepare in between
    run_phase(2, -1, 1'b0, 1'b0, 8);
    run_phase($urandom_range(0, 4), $urandom_range(0, 255), 1'b1, 1'b0, 8);
    run_phase(3, 0, 1'b1, 1'b1, 8);
    run_phase($urandom_range(0, 4), $urandom_range(0, 255), 1'b1, 1'b0, 8);

    wait_idle();
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
